FILE: hdl/hoe_pkg.sv
package hoe_pkg;

    // store and field geometry
    localparam int CODE_W      = 13;
    localparam int STORE_DEPTH = 1 << CODE_W;
    localparam int VAL_W       = 32;
    localparam int COORD_W     = 24;

    // deepest level allowed by the octree and by the code width
    localparam int MAX_DEPTH   = 4;
    localparam int CODE_LVLS   = (CODE_W - 1) / 3;
    localparam int DEPTH_TOP   = (MAX_DEPTH > CODE_LVLS) ? MAX_DEPTH : CODE_LVLS;
    localparam int DEPTH_W     = $clog2(DEPTH_TOP + 1);

    // a node can only have children when its code shifted by one level still fits
    localparam int KID_LIMIT   = 1 << (CODE_W - 3);

    // scaled center width: cube * (2k + 1) at the deepest level
    localparam int CW          = COORD_W + CODE_LVLS + 1;

    localparam logic [COORD_W-1:0] CUBE_RESET = COORD_W'(256);

    // opcodes
    localparam logic [1:0] OP_SUBDIVIDE = 2'd0;
    localparam logic [1:0] OP_WRITE     = 2'd1;
    localparam logic [1:0] OP_LOCATE    = 2'd2;
    localparam logic [1:0] OP_READ      = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ABSENT    = 2'd1;
    localparam logic [1:0] ST_NOT_LEAF  = 2'd2;
    localparam logic [1:0] ST_MAX_DEPTH = 2'd3;

    // one store entry
    typedef struct packed {
        logic               present;
        logic [VAL_W-1:0]   value;
    } t_node;

    // control of the center unit
    typedef struct packed {
        logic       load;
        logic       step;
        logic [2:0] oct;
    } t_geom_cmd;

    // point against center compare flags
    typedef struct packed {
        logic eq_x;
        logic gt_x;
        logic gt_y;
        logic gt_z;
    } t_geom_cmp;

    // depth of a code: highest level whose leading one lies above it
    function automatic logic [DEPTH_W-1:0] code_depth(input logic [CODE_W-1:0] code);
        logic [DEPTH_W-1:0] d;
        d = '0;
        for (int l = 1; l <= CODE_LVLS; l++) begin
            if ((code >> (3 * l)) != '0) begin
                d = DEPTH_W'(l);
            end
        end
        return d;
    endfunction

endpackage

FILE: hdl/hashed_octree_engine.sv
// Linear octree store addressed by locational code, one transaction in and exactly one
// result out per command. After reset the block sweeps its 8192-entry node memory (busy
// high, configuration writes still taken) and leaves only the root.
// A command is taken when start is high and busy low; busy then stays high until the
// result cycle, in which o_done pulses once and the next command may already be taken.
// The receiver cannot stall: o_done is high for that single cycle only; the result
// ports then hold until the next result. One memory access per cycle: read checks the
// node, then steps the centers to its level; an absent node ends after the check;
// subdivide does one write per child; write reads then writes each ancestor updated
// before writing the leaf; locate descends a level at a time before the read path.
// The centers come from one shared add/subtract unit stepped once per level.
module hashed_octree_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [hoe_pkg::COORD_W-1:0]         i_cfg_wdata,
    input  logic [1:0]                          i_opcode,
    input  logic [hoe_pkg::CODE_W-1:0]          i_node_code,
    input  logic signed [hoe_pkg::VAL_W-1:0]    i_new_value,
    input  logic [hoe_pkg::COORD_W-1:0]         i_px,
    input  logic [hoe_pkg::COORD_W-1:0]         i_py,
    input  logic [hoe_pkg::COORD_W-1:0]         i_pz,
    output logic                                o_done,
    output logic [1:0]                          o_status,
    output logic [hoe_pkg::CODE_W-1:0]          o_found_code,
    output logic signed [hoe_pkg::VAL_W-1:0]    o_node_value,
    output logic                                o_is_leaf,
    output logic [hoe_pkg::COORD_W-1:0]         o_half_size,
    output logic [hoe_pkg::COORD_W-1:0]         o_center_x,
    output logic [hoe_pkg::COORD_W-1:0]         o_center_y,
    output logic [hoe_pkg::COORD_W-1:0]         o_center_z
);
    import hoe_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOC_RD,
        S_LOC_CHK,
        S_N_RD,
        S_N_CHK,
        S_N_KID,
        S_SUB,
        S_W_DELTA,
        S_W_UPD,
        S_W_LEAF,
        S_G_LOAD,
        S_G_STEP,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [CODE_W-1:0]      r_clr;
    logic [COORD_W-1:0]     r_cube;

    // latched transaction
    logic [1:0]             r_op;
    logic [CODE_W-1:0]      r_code;
    logic [VAL_W-1:0]       r_nv;
    logic [COORD_W-1:0]     r_px, r_py, r_pz;

    // working state
    logic [1:0]             r_status;
    logic [VAL_W-1:0]       r_val;
    logic                   r_kids;
    logic [DEPTH_W-1:0]     r_depth;
    logic [DEPTH_W-1:0]     r_rem;
    logic [3:0]             r_cnt;
    logic [CODE_W-1:0]      r_anc;
    logic [VAL_W-1:0]       r_newer, r_older;
    logic [VAL_W-3:0]       r_delta;

    // result registers
    logic                   r_done;
    logic [1:0]             r_out_status;
    logic [CODE_W-1:0]      r_out_code;
    logic [VAL_W-1:0]       r_out_value;
    logic                   r_out_leaf;
    logic [COORD_W-1:0]     r_out_half;
    logic [COORD_W-1:0]     r_out_cx, r_out_cy, r_out_cz;

    // memory ports
    logic                   ram_we;
    logic [CODE_W-1:0]      ram_waddr;
    t_node                  ram_wdata;
    logic [CODE_W-1:0]      ram_raddr;
    t_node                  ram_rdata;

    // center unit
    t_geom_cmd              geom_cmd;
    t_geom_cmp              geom_cmp;
    logic [CW-1:0]          geom_cx, geom_cy, geom_cz;

    // derived values
    logic                   accept;
    logic                   kid_room;
    logic [CODE_W-1:0]      kid_code;
    logic [2:0]             loc_oct;
    logic [CODE_W-1:0]      loc_next;
    logic                   loc_stop;
    logic [DEPTH_W-1:0]     cur_depth;
    logic [DEPTH_W+1:0]     oct_sh;
    logic [CODE_W-1:0]      walk;
    logic [VAL_W:0]         w_diff;
    logic [VAL_W:0]         n_sum;
    logic [VAL_W-1:0]       n_sat;
    logic [DEPTH_W:0]       sh_amt;
    logic [2:0]             sub_kid;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign kid_room  = (r_code < CODE_W'(KID_LIMIT));
    assign kid_code  = {r_code[CODE_W-4:0], 3'b000};
    assign loc_oct   = {geom_cmp.gt_y, geom_cmp.gt_z, geom_cmp.gt_x};
    assign loc_next  = {r_code[CODE_W-4:0], loc_oct};
    assign loc_stop  = geom_cmp.eq_x || (r_depth >= DEPTH_W'(MAX_DEPTH)) || !kid_room;
    assign cur_depth = code_depth(r_code);
    assign sub_kid   = 3'(r_cnt - 4'd1);

    // octant of the level being walked, top level first
    assign oct_sh = {1'b0, r_rem, 1'b0} + {2'b00, r_rem};
    assign walk   = r_code >> oct_sh;

    // ancestor update: floor of the change over 8, then saturating add
    assign w_diff = {r_newer[VAL_W-1], r_newer} - {r_older[VAL_W-1], r_older};
    assign n_sum  = {{3{r_delta[VAL_W-3]}}, r_delta}
                  + {ram_rdata.value[VAL_W-1], ram_rdata.value};
    always_comb begin
        if (n_sum[VAL_W] != n_sum[VAL_W-1]) begin
            n_sat = n_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            n_sat = n_sum[VAL_W-1:0];
        end
    end

    assign sh_amt = {1'b0, r_depth} + 1'b1;

    // memory port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_code;
        ram_wdata = '{present: 1'b1, value: '0};
        ram_raddr = r_code;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '{present: (r_clr == CODE_W'(1)), value: '0};
            end
            S_LOC_CHK: begin
                ram_raddr = loc_next;
            end
            S_N_CHK: begin
                ram_raddr = kid_code;
            end
            S_SUB: begin
                ram_we    = 1'b1;
                ram_waddr = (r_cnt == 4'd0) ? r_code : {r_code[CODE_W-4:0], sub_kid};
            end
            S_W_DELTA: begin
                ram_raddr = r_anc;
            end
            S_W_UPD: begin
                ram_we    = 1'b1;
                ram_waddr = r_anc;
                ram_wdata = '{present: ram_rdata.present, value: n_sat};
            end
            S_W_LEAF: begin
                ram_we    = 1'b1;
                ram_wdata = '{present: 1'b1, value: r_nv};
            end
            default: begin
                ram_raddr = r_code;
            end
        endcase
    end

    // center unit control
    always_comb begin
        geom_cmd = '{load: 1'b0, step: 1'b0, oct: 3'b000};
        case (r_state)
            S_LOC_RD, S_G_LOAD: begin
                geom_cmd.load = 1'b1;
            end
            S_LOC_CHK: begin
                geom_cmd.step = ram_rdata.present && !loc_stop;
                geom_cmd.oct  = loc_oct;
            end
            S_G_STEP: begin
                geom_cmd.step = 1'b1;
                geom_cmd.oct  = walk[2:0];
            end
            default: begin
                geom_cmd.step = 1'b0;
            end
        endcase
    end

    // sequencer, working registers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cube  <= CUBE_RESET;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_cube <= i_cfg_wdata;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CODE_W'(STORE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= i_opcode;
                        r_nv     <= i_new_value;
                        r_px     <= i_px;
                        r_py     <= i_py;
                        r_pz     <= i_pz;
                        r_status <= ST_OK;
                        r_depth  <= '0;
                        if (i_opcode == OP_LOCATE) begin
                            r_code  <= CODE_W'(1);
                            r_state <= S_LOC_RD;
                        end else begin
                            r_code  <= i_node_code;
                            r_state <= S_N_RD;
                        end
                    end
                end
                S_LOC_RD: begin
                    r_state <= S_LOC_CHK;
                end
                S_LOC_CHK: begin
                    // missing node ends at parent, else stop tests, else go down
                    if (!ram_rdata.present) begin
                        if (r_depth != '0) begin
                            r_code <= r_code >> 3;
                        end
                        r_state <= S_N_RD;
                    end else if (loc_stop) begin
                        r_state <= S_N_RD;
                    end else begin
                        r_code  <= loc_next;
                        r_depth <= r_depth + 1'b1;
                    end
                end
                S_N_RD: begin
                    r_state <= S_N_CHK;
                end
                S_N_CHK: begin
                    if (!ram_rdata.present) begin
                        r_status <= ST_ABSENT;
                        r_state  <= S_DONE;
                    end else begin
                        r_val   <= ram_rdata.value;
                        r_state <= S_N_KID;
                    end
                end
                S_N_KID: begin
                    r_kids  <= kid_room && ram_rdata.present;
                    r_state <= S_G_LOAD;
                    case (r_op)
                        OP_SUBDIVIDE: begin
                            if (cur_depth >= DEPTH_W'(MAX_DEPTH) || !kid_room) begin
                                r_status <= ST_MAX_DEPTH;
                            end else begin
                                r_cnt   <= '0;
                                r_state <= S_SUB;
                            end
                        end
                        OP_WRITE: begin
                            if (kid_room && ram_rdata.present) begin
                                r_status <= ST_NOT_LEAF;
                            end else begin
                                r_newer <= r_nv;
                                r_older <= r_val;
                                r_anc   <= r_code >> 3;
                                r_state <= ((r_code >> 3) == '0) ? S_W_LEAF : S_W_DELTA;
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                        end
                    endcase
                end
                S_SUB: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd8) begin
                        r_val   <= '0;
                        r_kids  <= 1'b1;
                        r_state <= S_G_LOAD;
                    end
                end
                S_W_DELTA: begin
                    r_delta <= w_diff[VAL_W:3];
                    r_state <= S_W_UPD;
                end
                S_W_UPD: begin
                    r_older <= ram_rdata.value;
                    r_newer <= n_sat;
                    r_anc   <= r_anc >> 3;
                    r_state <= ((r_anc >> 3) == '0) ? S_W_LEAF : S_W_DELTA;
                end
                S_W_LEAF: begin
                    r_val   <= r_nv;
                    r_kids  <= 1'b0;
                    r_state <= S_G_LOAD;
                end
                S_G_LOAD: begin
                    r_depth <= cur_depth;
                    r_rem   <= cur_depth - 1'b1;
                    r_state <= (cur_depth == '0) ? S_DONE : S_G_STEP;
                end
                S_G_STEP: begin
                    r_rem <= r_rem - 1'b1;
                    if (r_rem == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done       <= 1'b1;
                    r_out_status <= r_status;
                    r_out_code   <= r_code;
                    if (r_status == ST_ABSENT) begin
                        r_out_value <= '0;
                        r_out_leaf  <= 1'b0;
                        r_out_half  <= '0;
                        r_out_cx    <= '0;
                        r_out_cy    <= '0;
                        r_out_cz    <= '0;
                    end else begin
                        r_out_value <= r_val;
                        r_out_leaf  <= !r_kids;
                        r_out_half  <= r_cube >> sh_amt;
                        r_out_cx    <= COORD_W'(geom_cx >> sh_amt);
                        r_out_cy    <= COORD_W'(geom_cy >> sh_amt);
                        r_out_cz    <= COORD_W'(geom_cz >> sh_amt);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    hoe_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hoe_geom u_geom (
        .i_clk  (i_clk),
        .i_cmd  (geom_cmd),
        .i_cube (r_cube),
        .i_px   (r_px),
        .i_py   (r_py),
        .i_pz   (r_pz),
        .o_cmp  (geom_cmp),
        .o_cx   (geom_cx),
        .o_cy   (geom_cy),
        .o_cz   (geom_cz)
    );

    assign o_done       = r_done;
    assign o_status     = r_out_status;
    assign o_found_code = r_out_code;
    assign o_node_value = r_out_value;
    assign o_is_leaf    = r_out_leaf;
    assign o_half_size  = r_out_half;
    assign o_center_x   = r_out_cx;
    assign o_center_y   = r_out_cy;
    assign o_center_z   = r_out_cz;

    // one result per transaction, a single-cycle strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a transaction");

    // the result cycle is also a ready cycle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result given while still busy");

    // an absent node reports nothing but its code
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_ABSENT) |->
            (o_node_value == '0 && !o_is_leaf && o_half_size == '0))
        else $error("absent node result carries data");

    // a successful split leaves children behind
    a_split_kids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_op == OP_SUBDIVIDE && o_status == ST_OK) |-> !o_is_leaf)
        else $error("subdivided node reported as leaf");

endmodule

FILE: hdl/hoe_ram.sv
module hoe_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/hoe_geom.sv
module hoe_geom (
    input  logic                          i_clk,
    input  hoe_pkg::t_geom_cmd            i_cmd,
    input  logic [hoe_pkg::COORD_W-1:0]   i_cube,
    input  logic [hoe_pkg::COORD_W-1:0]   i_px,
    input  logic [hoe_pkg::COORD_W-1:0]   i_py,
    input  logic [hoe_pkg::COORD_W-1:0]   i_pz,
    output hoe_pkg::t_geom_cmp            o_cmp,
    output logic [hoe_pkg::CW-1:0]        o_cx,
    output logic [hoe_pkg::CW-1:0]        o_cy,
    output logic [hoe_pkg::CW-1:0]        o_cz
);
    import hoe_pkg::*;

    // scaled centers cube*(2k+1) and scaled point p<<(d+1)
    logic [CW-1:0] r_cx, r_cy, r_cz;
    logic [CW-1:0] r_sx, r_sy, r_sz;

    // one level down: center doubles, then moves a cube up or down
    function automatic logic [CW-1:0] next_c(input logic [CW-1:0] c,
                                             input logic [COORD_W-1:0] cube,
                                             input logic up);
        logic [CW-1:0] dbl;
        dbl = {c[CW-2:0], 1'b0};
        return up ? (dbl + CW'(cube)) : (dbl - CW'(cube));
    endfunction

    // level step: octant bit 0 is x, bit 1 is z, bit 2 is y
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= CW'(i_cube);
            r_cy <= CW'(i_cube);
            r_cz <= CW'(i_cube);
            r_sx <= CW'({i_px, 1'b0});
            r_sy <= CW'({i_py, 1'b0});
            r_sz <= CW'({i_pz, 1'b0});
        end else if (i_cmd.step) begin
            r_cx <= next_c(r_cx, i_cube, i_cmd.oct[0]);
            r_cz <= next_c(r_cz, i_cube, i_cmd.oct[1]);
            r_cy <= next_c(r_cy, i_cube, i_cmd.oct[2]);
            r_sx <= {r_sx[CW-2:0], 1'b0};
            r_sy <= {r_sy[CW-2:0], 1'b0};
            r_sz <= {r_sz[CW-2:0], 1'b0};
        end
    end

    // exact compares against the unrounded center
    always_comb begin
        o_cmp.eq_x = (r_sx == r_cx);
        o_cmp.gt_x = (r_sx > r_cx);
        o_cmp.gt_y = (r_sy > r_cy);
        o_cmp.gt_z = (r_sz > r_cz);
    end

    assign o_cx = r_cx;
    assign o_cy = r_cy;
    assign o_cz = r_cz;

endmodule
